// ===== rtl/irsa_peeling_decoder_unit_macros.svh =====
// Assertion macros for the IRSA peeling decoder.
`ifndef IRSA_PEELING_DECODER_UNIT_MACROS_SVH
`define IRSA_PEELING_DECODER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IRSA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define IRSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define IRSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IRSA_ASSERT_NEVER(lbl, cond, msg)
`define IRSA_ASSERT_IMP(lbl, ante, cons, msg)
`define IRSA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/irsa_pkg.sv =====
// Types and constants shared by the IRSA peeling decoder modules.
`default_nettype none
package irsa_pkg;
  localparam int MAX_REPLICAS   = 64;
  localparam int SLOT_BITS      = 8;
  localparam int PACKET_ID_BITS = 16;
  localparam int IDX_BITS       = $clog2(MAX_REPLICAS);
  localparam int CNT_BITS       = $clog2(MAX_REPLICAS + 1);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {KIND_STORE, KIND_EOF} kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [PACKET_ID_BITS-1:0] pkt;
    logic [SLOT_BITS-1:0]      slot;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } handoff_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHK_I, ST_LOAD_I, ST_SCAN_RD, ST_SCAN_EV, ST_MARK_RD, ST_MARK_EV, ST_PASS
  } back_st_t;
endpackage
`default_nettype wire

// ===== rtl/irsa_front.sv =====
// Front end: accepts and classifies items and queues them for the back end.
`default_nettype none
module irsa_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_operation,
  input  wire logic [15:0]       in_packet_id,
  input  wire logic [7:0]        in_slot_id,
  input  wire logic              pop,
  output irsa_pkg::handoff_t     head
);
  irsa_pkg::item_t                  q_r [irsa_pkg::QUEUE_DEPTH];
  logic [irsa_pkg::QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [irsa_pkg::QCNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                             push, do_pop;
  irsa_pkg::item_t                  item;

  assign busy   = (cnt_r == irsa_pkg::QCNT_BITS'(irsa_pkg::QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    item.kind = in_operation ? irsa_pkg::KIND_EOF : irsa_pkg::KIND_STORE;
    item.pkt  = irsa_pkg::PACKET_ID_BITS'(in_packet_id);
    item.slot = irsa_pkg::SLOT_BITS'(in_slot_id);
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == irsa_pkg::QPTR_BITS'(irsa_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == irsa_pkg::QPTR_BITS'(irsa_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + irsa_pkg::QCNT_BITS'(push) - irsa_pkg::QCNT_BITS'(do_pop);
    head.valid = (cnt_r != '0);
    head.item  = q_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/irsa_back.sv =====
// Back end: replica store and iterative peeling sequencer.
`default_nettype none
`include "irsa_peeling_decoder_unit_macros.svh"
module irsa_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire irsa_pkg::handoff_t head,
  output logic                    pop,
  output logic                    out_valid,
  output logic [6:0]              out_frame_decoded,
  output logic [31:0]             out_total_decoded,
  output logic                    out_frame_overflow
);
  localparam int IW = irsa_pkg::IDX_BITS;
  localparam int CW = irsa_pkg::CNT_BITS;

  logic [irsa_pkg::PACKET_ID_BITS-1:0] mem_pkt [irsa_pkg::MAX_REPLICAS];
  logic [irsa_pkg::SLOT_BITS-1:0]      mem_slot [irsa_pkg::MAX_REPLICAS];
  logic [irsa_pkg::PACKET_ID_BITS-1:0] rd_pkt_r, cur_pkt_r, cur_pkt_nxt;
  logic [irsa_pkg::SLOT_BITS-1:0]      rd_slot_r, cur_slot_r, cur_slot_nxt;
  logic [IW-1:0]                       rd_addr;
  logic                                wr_en;

  irsa_pkg::back_st_t          st_r, st_nxt;
  logic [irsa_pkg::MAX_REPLICAS-1:0] clean_r, clean_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt, found_r, found_nxt;
  logic                        ovf_r, ovf_nxt, chg_r, chg_nxt;
  logic [31:0]                 total_r, total_nxt;
  logic                        ov_r, ov_nxt;
  logic [6:0]                  ofd_r, ofd_nxt;
  logic                        oovf_r, oovf_nxt;

  assign pop                = (st_r == irsa_pkg::ST_IDLE);
  assign out_valid          = ov_r;
  assign out_frame_decoded  = ofd_r;
  assign out_total_decoded  = total_r;
  assign out_frame_overflow = oovf_r;

  always_comb begin
    st_nxt       = st_r;
    clean_nxt    = clean_r;
    cnt_nxt      = cnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    found_nxt    = found_r;
    ovf_nxt      = ovf_r;
    chg_nxt      = chg_r;
    total_nxt    = total_r;
    ov_nxt       = 1'b0;
    ofd_nxt      = ofd_r;
    oovf_nxt     = oovf_r;
    cur_pkt_nxt  = cur_pkt_r;
    cur_slot_nxt = cur_slot_r;
    rd_addr      = '0;
    wr_en        = 1'b0;
    case (st_r)
      irsa_pkg::ST_IDLE: begin
        if (head.valid) begin
          if (head.item.kind == irsa_pkg::KIND_STORE) begin
            if (cnt_r < CW'(irsa_pkg::MAX_REPLICAS)) begin
              wr_en                   = 1'b1;
              clean_nxt[cnt_r[IW-1:0]] = 1'b0;
              cnt_nxt                 = cnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            i_nxt     = '0;
            chg_nxt   = 1'b0;
            found_nxt = '0;
            st_nxt    = irsa_pkg::ST_CHK_I;
          end
        end
      end
      irsa_pkg::ST_CHK_I: begin
        if (i_r == cnt_r) begin
          st_nxt = irsa_pkg::ST_PASS;
        end else if (clean_r[i_r[IW-1:0]]) begin
          i_nxt = i_r + 1'b1;
        end else begin
          rd_addr = i_r[IW-1:0];
          st_nxt  = irsa_pkg::ST_LOAD_I;
        end
      end
      irsa_pkg::ST_LOAD_I: begin
        cur_pkt_nxt  = rd_pkt_r;
        cur_slot_nxt = rd_slot_r;
        j_nxt        = '0;
        st_nxt       = irsa_pkg::ST_SCAN_RD;
      end
      irsa_pkg::ST_SCAN_RD: begin
        if (j_r == cnt_r) begin
          found_nxt = found_r + 1'b1;
          chg_nxt   = 1'b1;
          j_nxt     = '0;
          st_nxt    = irsa_pkg::ST_MARK_RD;
        end else begin
          rd_addr = j_r[IW-1:0];
          st_nxt  = irsa_pkg::ST_SCAN_EV;
        end
      end
      irsa_pkg::ST_SCAN_EV: begin
        if (rd_slot_r == cur_slot_r && rd_pkt_r != cur_pkt_r && !clean_r[j_r[IW-1:0]]) begin
          i_nxt  = i_r + 1'b1;
          st_nxt = irsa_pkg::ST_CHK_I;
        end else begin
          j_nxt  = j_r + 1'b1;
          st_nxt = irsa_pkg::ST_SCAN_RD;
        end
      end
      irsa_pkg::ST_MARK_RD: begin
        if (j_r == cnt_r) begin
          i_nxt  = i_r + 1'b1;
          st_nxt = irsa_pkg::ST_CHK_I;
        end else begin
          rd_addr = j_r[IW-1:0];
          st_nxt  = irsa_pkg::ST_MARK_EV;
        end
      end
      irsa_pkg::ST_MARK_EV: begin
        if (rd_pkt_r == cur_pkt_r) begin
          clean_nxt[j_r[IW-1:0]] = 1'b1;
        end
        j_nxt  = j_r + 1'b1;
        st_nxt = irsa_pkg::ST_MARK_RD;
      end
      irsa_pkg::ST_PASS: begin
        if (chg_r) begin
          i_nxt   = '0;
          chg_nxt = 1'b0;
          st_nxt  = irsa_pkg::ST_CHK_I;
        end else begin
          total_nxt = total_r + 32'(found_r);
          ov_nxt    = 1'b1;
          ofd_nxt   = 7'(found_r);
          oovf_nxt  = ovf_r;
          clean_nxt = '0;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          st_nxt    = irsa_pkg::ST_IDLE;
        end
      end
      default: st_nxt = irsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= irsa_pkg::ST_IDLE;
      clean_r <= '0;
      cnt_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      found_r <= '0;
      ovf_r   <= 1'b0;
      chg_r   <= 1'b0;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      clean_r <= clean_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      found_r <= found_nxt;
      ovf_r   <= ovf_nxt;
      chg_r   <= chg_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ofd_r      <= ofd_nxt;
    oovf_r     <= oovf_nxt;
    cur_pkt_r  <= cur_pkt_nxt;
    cur_slot_r <= cur_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_pkt[cnt_r[IW-1:0]]  <= head.item.pkt;
      mem_slot[cnt_r[IW-1:0]] <= head.item.slot;
    end
    rd_pkt_r  <= mem_pkt[rd_addr];
    rd_slot_r <= mem_slot[rd_addr];
  end

  `IRSA_ASSERT_NEVER(a_cnt_range, cnt_r > CW'(irsa_pkg::MAX_REPLICAS), "replica count overrun")
  `IRSA_ASSERT_NEXT(a_strobe_once, ov_r, !ov_r, "result strobe held")
  `IRSA_ASSERT_IMP(a_strobe_src, ov_r, $past(st_r) == irsa_pkg::ST_PASS, "stray result")
  `IRSA_ASSERT_IMP(a_found_range, st_r != irsa_pkg::ST_IDLE, found_r <= cnt_r, "found overrun")
endmodule
`default_nettype wire

// ===== rtl/irsa_peeling_decoder_unit.sv =====
// Store items: accepted while busy is low; while idle, the back end retires one per cycle from a two-entry queue.
// End of frame: each pass skips clean replicas; a replica sharing its slot with another packet is blocked,
// else its packet's replicas are marked clean; passes repeat until one decodes nothing.
// The result strobe is registered, rising in the cycle after the last pass, and lasts one cycle; no output stall.
// Synchronous active-low reset clears the queue, store count, clean bits and total.
`default_nettype none
module irsa_peeling_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [15:0] in_packet_id,
  input  wire logic [7:0]  in_slot_id,
  output logic             out_valid,
  output logic [6:0]       out_frame_decoded,
  output logic [31:0]      out_total_decoded,
  output logic             out_frame_overflow
);
  irsa_pkg::handoff_t head;
  logic               pop;

  irsa_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_packet_id(in_packet_id), .in_slot_id(in_slot_id),
    .pop(pop), .head(head)
  );

  irsa_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
    .out_valid(out_valid), .out_frame_decoded(out_frame_decoded),
    .out_total_decoded(out_total_decoded), .out_frame_overflow(out_frame_overflow)
  );
endmodule
`default_nettype wire
